// ----- rtl/core/report_pattern_learner_defines.svh -----
// Assertion macros for the report pattern learner.
// Simulation builds get concurrent assertions; synthesis builds get nothing.
`ifndef REPORT_PATTERN_LEARNER_DEFINES_SVH
`define REPORT_PATTERN_LEARNER_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked outside reset.
`define RPL_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define RPL_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define RPL_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define RPL_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

// ----- rtl/core/rpl_pkg.sv -----
package rpl_pkg;

  // Operation codes carried by every request.
  typedef enum logic [1:0] {
    OP_OCTET   = 2'd0,
    OP_CONFIRM = 2'd1,
    OP_CANCEL  = 2'd2,
    OP_RESTART = 2'd3
  } op_e;

  // Outcome codes of a result.
  typedef enum logic [2:0] {
    OUT_IGNORED  = 3'd0,
    OUT_PRESS    = 3'd1,
    OUT_REPEAT   = 3'd2,
    OUT_CYCLE    = 3'd3,
    OUT_REJECTED = 3'd4,
    OUT_READY    = 3'd5
  } outcome_e;

  // A classified request as it travels from the front to the back.
  typedef struct packed {
    op_e         op;
    logic [7:0]  octet;
    logic [15:0] endpoint;
    logic        first;     // first octet of a report
    logic        in_range;  // octet falls inside the pattern store
    logic        last;      // final octet of a report
    logic        oversize;  // report has run past the store
  } rpl_item_t;

  // One result as it waits for the consumer.
  typedef struct packed {
    outcome_e   outcome;
    logic       confirm_acc;
    logic [2:0] stage;
  } rpl_result_t;

endpackage

// ----- rtl/core/rpl_front.sv -----
module rpl_front #(
  parameter int MAX_REPORT_OCTETS = 64
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 push_i,
  output logic                                 full_o,
  input  logic [1:0]                           operation_i,
  input  logic [7:0]                           report_octet_i,
  input  logic [15:0]                          endpoint_id_i,
  input  logic                                 final_octet_i,
  input  logic                                 pop_i,
  output logic                                 valid_o,
  output rpl_pkg::rpl_item_t                   item_o,
  output logic [((MAX_REPORT_OCTETS > 1) ? $clog2(MAX_REPORT_OCTETS) : 1)-1:0] idx_o
);

  localparam int CntW = $clog2(MAX_REPORT_OCTETS + 1);
  localparam int IdxW = (MAX_REPORT_OCTETS > 1) ? $clog2(MAX_REPORT_OCTETS) : 1;
  localparam logic [CntW-1:0] MaxCnt = CntW'(MAX_REPORT_OCTETS);

  logic [CntW-1:0]    cnt_q, cnt_d;
  logic               ovf_q, ovf_d;
  logic               accept;
  rpl_pkg::rpl_item_t item_in;

  rpl_pkg::rpl_item_t q_item_q [2];
  logic [IdxW-1:0]    q_idx_q  [2];
  logic               wr_ptr_q, rd_ptr_q;
  logic [1:0]         count_q, count_d;

  assign full_o  = (count_q == 2'd2);
  assign accept  = push_i && !full_o;
  assign valid_o = (count_q != 2'd0);
  assign item_o  = q_item_q[rd_ptr_q];
  assign idx_o   = q_idx_q[rd_ptr_q];

  // Classify the incoming request against the position inside the current report.
  always_comb begin
    item_in.op       = rpl_pkg::op_e'(operation_i);
    item_in.octet    = report_octet_i;
    item_in.endpoint = endpoint_id_i;
    item_in.first    = (cnt_q == '0);
    item_in.in_range = (cnt_q < MaxCnt);
    item_in.last     = final_octet_i;
    item_in.oversize = ovf_q || (cnt_q >= MaxCnt);
  end

  // Octet position tracking; any control operation or a final octet starts a new report.
  always_comb begin
    cnt_d = cnt_q;
    ovf_d = ovf_q;
    if (accept) begin
      if (item_in.op != rpl_pkg::OP_OCTET || final_octet_i) begin
        cnt_d = '0;
        ovf_d = 1'b0;
      end else begin
        cnt_d = item_in.in_range ? cnt_q + CntW'(1) : cnt_q;
        ovf_d = item_in.oversize;
      end
    end
  end

  assign count_d = count_q + {1'b0, accept} - {1'b0, pop_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      ovf_q    <= 1'b0;
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      cnt_q   <= cnt_d;
      ovf_q   <= ovf_d;
      count_q <= count_d;
      if (accept) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
    end
  end

  // Queue storage toward the back part.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      q_item_q[wr_ptr_q] <= item_in;
      q_idx_q[wr_ptr_q]  <= cnt_q[IdxW-1:0];
    end
  end

endmodule

// ----- rtl/core/rpl_back.sv -----
module rpl_back #(
  parameter int MAX_REPORT_OCTETS = 64
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  head_valid_i,
  input  rpl_pkg::rpl_item_t    head_i,
  input  logic [((MAX_REPORT_OCTETS > 1) ? $clog2(MAX_REPORT_OCTETS) : 1)-1:0] head_idx_i,
  output logic                  head_pop_o,
  input  logic                  res_space_i,
  output logic                  res_valid_o,
  output rpl_pkg::rpl_result_t  res_o
);

  localparam int CntW = $clog2(MAX_REPORT_OCTETS + 1);
  localparam int IdxW = (MAX_REPORT_OCTETS > 1) ? $clog2(MAX_REPORT_OCTETS) : 1;

  typedef enum logic [2:0] {
    ST_FIRST_PRESS    = 3'd0,
    ST_FIRST_RELEASE  = 3'd1,
    ST_SECOND_PRESS   = 3'd2,
    ST_SECOND_RELEASE = 3'd3,
    ST_AWAIT          = 3'd4,
    ST_COMPLETE       = 3'd5,
    ST_FAILED         = 3'd6
  } stage_e;

  stage_e             stage_q, stage_d;
  logic [15:0]        learned_ep_q, learned_ep_d;
  logic [15:0]        cur_ep_q, cur_ep_d;
  logic [CntW-1:0]    press_cnt_q, press_cnt_d;
  logic [CntW-1:0]    rel_cnt_q, rel_cnt_d;
  logic               pm_q, pm_d;
  logic               rm_q, rm_d;
  logic               s2_valid_q, s2_valid_d;

  rpl_pkg::rpl_item_t s2_q;
  logic [IdxW-1:0]    s2_idx_q;
  logic [7:0]         press_rd_q, rel_rd_q;

  logic [7:0]         press_mem [MAX_REPORT_OCTETS];
  logic [7:0]         rel_mem   [MAX_REPORT_OCTETS];

  logic               needs_out, fire;
  logic               press_we, rel_we;
  logic [CntW-1:0]    length;
  logic               pm_upd, rm_upd, is_press, is_rel;
  logic [15:0]        ep_eff;

  // Handshake of the compare stage.
  assign needs_out  = s2_valid_q && (s2_q.op != rpl_pkg::OP_OCTET || s2_q.last);
  assign fire       = s2_valid_q && (!needs_out || res_space_i);
  assign head_pop_o = head_valid_i && (!s2_valid_q || fire);
  assign s2_valid_d = head_pop_o ? 1'b1 : (fire ? 1'b0 : s2_valid_q);

  // Stores are written in the compare stage, where the stage of learning is settled.
  assign press_we = fire && s2_q.op == rpl_pkg::OP_OCTET && s2_q.in_range &&
                    stage_q == ST_FIRST_PRESS;
  assign rel_we   = fire && s2_q.op == rpl_pkg::OP_OCTET && s2_q.in_range &&
                    stage_q == ST_FIRST_RELEASE;

  // Running match of the current report against both stored patterns.
  assign length = CntW'(s2_idx_q) + CntW'(1);
  assign pm_upd = s2_q.in_range ?
                  (pm_q && CntW'(s2_idx_q) < press_cnt_q && press_rd_q == s2_q.octet) : pm_q;
  assign rm_upd = s2_q.in_range ?
                  (rm_q && CntW'(s2_idx_q) < rel_cnt_q && rel_rd_q == s2_q.octet) : rm_q;
  assign is_press = pm_upd && length == press_cnt_q;
  assign is_rel   = rm_upd && length == rel_cnt_q;
  assign ep_eff   = s2_q.first ? s2_q.endpoint : cur_ep_q;

  // Learning sequence and result generation.
  always_comb begin
    stage_d           = stage_q;
    learned_ep_d      = learned_ep_q;
    cur_ep_d          = cur_ep_q;
    press_cnt_d       = press_cnt_q;
    rel_cnt_d         = rel_cnt_q;
    pm_d              = pm_q;
    rm_d              = rm_q;
    res_o.outcome     = rpl_pkg::OUT_IGNORED;
    res_o.confirm_acc = 1'b0;
    if (fire) begin
      unique case (s2_q.op)
        rpl_pkg::OP_OCTET: begin
          if (s2_q.first) begin
            cur_ep_d = s2_q.endpoint;
          end
          pm_d = pm_upd;
          rm_d = rm_upd;
          if (s2_q.last) begin
            pm_d = 1'b1;
            rm_d = 1'b1;
            if (!s2_q.oversize) begin
              unique case (stage_q)
                ST_FIRST_PRESS: begin
                  learned_ep_d  = ep_eff;
                  press_cnt_d   = length;
                  stage_d       = ST_FIRST_RELEASE;
                  res_o.outcome = rpl_pkg::OUT_PRESS;
                end
                ST_FIRST_RELEASE: begin
                  priority if (ep_eff != learned_ep_q) begin
                    stage_d       = ST_FAILED;
                    res_o.outcome = rpl_pkg::OUT_REJECTED;
                  end else if (is_press) begin
                    res_o.outcome = rpl_pkg::OUT_REPEAT;
                  end else begin
                    rel_cnt_d     = length;
                    stage_d       = ST_SECOND_PRESS;
                    res_o.outcome = rpl_pkg::OUT_CYCLE;
                  end
                end
                ST_SECOND_PRESS: begin
                  priority if (ep_eff != learned_ep_q || (!is_rel && !is_press)) begin
                    stage_d       = ST_FAILED;
                    res_o.outcome = rpl_pkg::OUT_REJECTED;
                  end else if (is_rel) begin
                    res_o.outcome = rpl_pkg::OUT_REPEAT;
                  end else begin
                    stage_d       = ST_SECOND_RELEASE;
                    res_o.outcome = rpl_pkg::OUT_PRESS;
                  end
                end
                ST_SECOND_RELEASE: begin
                  priority if (ep_eff != learned_ep_q || (!is_press && !is_rel)) begin
                    stage_d       = ST_FAILED;
                    res_o.outcome = rpl_pkg::OUT_REJECTED;
                  end else if (is_press) begin
                    res_o.outcome = rpl_pkg::OUT_REPEAT;
                  end else begin
                    stage_d       = ST_AWAIT;
                    res_o.outcome = rpl_pkg::OUT_READY;
                  end
                end
                default: begin
                  // Reports after learning has settled are ignored.
                  stage_d = stage_q;
                end
              endcase
            end
          end
        end
        rpl_pkg::OP_CONFIRM: begin
          pm_d = 1'b1;
          rm_d = 1'b1;
          if (stage_q == ST_AWAIT) begin
            stage_d           = ST_COMPLETE;
            res_o.confirm_acc = 1'b1;
          end
        end
        rpl_pkg::OP_CANCEL: begin
          pm_d    = 1'b1;
          rm_d    = 1'b1;
          stage_d = ST_FAILED;
        end
        rpl_pkg::OP_RESTART: begin
          pm_d         = 1'b1;
          rm_d         = 1'b1;
          stage_d      = ST_FIRST_PRESS;
          learned_ep_d = '0;
          press_cnt_d  = '0;
          rel_cnt_d    = '0;
        end
      endcase
    end
    res_o.stage = stage_d;
  end

  assign res_valid_o = fire && needs_out;

  // Learning state and stage control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_q      <= ST_FIRST_PRESS;
      learned_ep_q <= '0;
      cur_ep_q     <= '0;
      press_cnt_q  <= '0;
      rel_cnt_q    <= '0;
      pm_q         <= 1'b1;
      rm_q         <= 1'b1;
      s2_valid_q   <= 1'b0;
    end else begin
      stage_q      <= stage_d;
      learned_ep_q <= learned_ep_d;
      cur_ep_q     <= cur_ep_d;
      press_cnt_q  <= press_cnt_d;
      rel_cnt_q    <= rel_cnt_d;
      pm_q         <= pm_d;
      rm_q         <= rm_d;
      s2_valid_q   <= s2_valid_d;
    end
  end

  // Compare stage payload, loaded as the head of the queue is taken.
  always_ff @(posedge clk_i) begin
    if (head_pop_o) begin
      s2_q     <= head_i;
      s2_idx_q <= head_idx_i;
    end
  end

  // Press pattern store; a write to the address being read is forwarded.
  always_ff @(posedge clk_i) begin
    if (press_we) begin
      press_mem[s2_idx_q] <= s2_q.octet;
    end
  end

  always_ff @(posedge clk_i) begin
    if (head_pop_o) begin
      if (press_we && s2_idx_q == head_idx_i) begin
        press_rd_q <= s2_q.octet;
      end else begin
        press_rd_q <= press_mem[head_idx_i];
      end
    end
  end

  // Release pattern store, same arrangement.
  always_ff @(posedge clk_i) begin
    if (rel_we) begin
      rel_mem[s2_idx_q] <= s2_q.octet;
    end
  end

  always_ff @(posedge clk_i) begin
    if (head_pop_o) begin
      if (rel_we && s2_idx_q == head_idx_i) begin
        rel_rd_q <= s2_q.octet;
      end else begin
        rel_rd_q <= rel_mem[head_idx_i];
      end
    end
  end

endmodule

// ----- rtl/core/rpl_res_fifo.sv -----
module rpl_res_fifo (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  rpl_pkg::rpl_result_t data_i,
  output logic                 space_o,
  input  logic                 pop_i,
  output logic                 empty_o,
  output rpl_pkg::rpl_result_t data_o
);

  rpl_pkg::rpl_result_t mem_q [2];
  logic                 wr_ptr_q, rd_ptr_q;
  logic [1:0]           count_q;
  logic                 do_pop;

  assign space_o = (count_q != 2'd2);
  assign empty_o = (count_q == 2'd0);
  assign data_o  = mem_q[rd_ptr_q];
  assign do_pop  = pop_i && !empty_o;

  // Occupancy and pointers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      count_q <= count_q + {1'b0, push_i} - {1'b0, do_pop};
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (do_pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
    end
  end

  // Result storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// ----- rtl/core/report_pattern_learner.sv -----
// A request's result passes through the front queue, the compare stage and the result
// queue, held up only while the consumer stalls. Throughput: one request per
// cycle unless the consumer stalls, set by the single-port read of the pattern stores
// in the back stage; a two-entry queue on each side decouples producer and consumer.
// Reset (rst_ni, asynchronous, active low) clears all control state, stage, endpoints
// and lengths at once; the pattern stores are not cleared and need no clearing pass.
`include "report_pattern_learner_defines.svh"

module report_pattern_learner #(
  parameter int MAX_REPORT_OCTETS = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  operation_i,
  input  logic [7:0]  report_octet_i,
  input  logic [15:0] endpoint_id_i,
  input  logic        final_octet_i,
  output logic        empty,
  input  logic        pop,
  output logic [2:0]  outcome_o,
  output logic        confirm_accepted_o,
  output logic [2:0]  learn_stage_o
);

  localparam int IdxW = (MAX_REPORT_OCTETS > 1) ? $clog2(MAX_REPORT_OCTETS) : 1;

  logic                 front_valid, front_pop;
  rpl_pkg::rpl_item_t   front_item;
  logic [IdxW-1:0]      front_idx;
  logic                 res_valid, res_space;
  rpl_pkg::rpl_result_t res_data, res_head;

  // Front: report position tracking and the request queue.
  rpl_front #(
    .MAX_REPORT_OCTETS(MAX_REPORT_OCTETS)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push_i        (push),
    .full_o        (full),
    .operation_i   (operation_i),
    .report_octet_i(report_octet_i),
    .endpoint_id_i (endpoint_id_i),
    .final_octet_i (final_octet_i),
    .pop_i         (front_pop),
    .valid_o       (front_valid),
    .item_o        (front_item),
    .idx_o         (front_idx)
  );

  // Back: pattern stores, matching and the learning sequence.
  rpl_back #(
    .MAX_REPORT_OCTETS(MAX_REPORT_OCTETS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_valid_i(front_valid),
    .head_i      (front_item),
    .head_idx_i  (front_idx),
    .head_pop_o  (front_pop),
    .res_space_i (res_space),
    .res_valid_o (res_valid),
    .res_o       (res_data)
  );

  // Result queue toward the consumer.
  rpl_res_fifo u_res_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (res_valid),
    .data_i (res_data),
    .space_o(res_space),
    .pop_i  (pop),
    .empty_o(empty),
    .data_o (res_head)
  );

  assign outcome_o          = res_head.outcome;
  assign confirm_accepted_o = res_head.confirm_acc;
  assign learn_stage_o      = res_head.stage;

  // A result is only produced when the result queue can take it.
  `RPL_ASSERT_IMP(a_res_space, clk_i, rst_ni, res_valid, res_space, "result pushed into full queue")

  // An accepted confirm is never reported with a report outcome.
  `RPL_ASSERT_IMP(a_confirm_ignored, clk_i, rst_ni, !empty && confirm_accepted_o, outcome_o == rpl_pkg::OUT_IGNORED, "confirm result carries an outcome")

  // An accepted request is waiting in the front queue on the next cycle.
  `RPL_ASSERT_NXT(a_front_holds, clk_i, rst_ni, push && !full, front_valid, "accepted request lost")

endmodule

// ----- sim/report_pattern_learner_test.sv -----
module report_pattern_learner_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_OCTETS = 64;
  localparam int RANDOM_ITEMS = 1320;

  // Learning stages as reported on learn_stage_o.
  localparam logic [2:0] LS_FIRST_PRESS = 3'd0;
  localparam logic [2:0] LS_FIRST_RELEASE = 3'd1;
  localparam logic [2:0] LS_SECOND_PRESS = 3'd2;
  localparam logic [2:0] LS_SECOND_RELEASE = 3'd3;
  localparam logic [2:0] LS_AWAIT = 3'd4;
  localparam logic [2:0] LS_COMPLETE = 3'd5;
  localparam logic [2:0] LS_FAILED = 3'd6;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic push_req = 1'b0;
  logic req_full;
  rpl_pkg::op_e operation = rpl_pkg::OP_OCTET;
  logic [7:0] octet_in = 8'h00;
  logic [15:0] endpoint_in = 16'h0000;
  logic final_in = 1'b0;
  logic res_empty;
  logic pop_req = 1'b0;
  logic [2:0] outcome_out;
  logic accepted_out;
  logic [2:0] stage_out;

  // Shadow copy of the learner state.
  logic [2:0] model_stage;
  logic [15:0] model_learned_ep;
  logic [15:0] model_report_ep;
  logic [7:0] press_pattern [MAX_OCTETS];
  logic [7:0] release_pattern [MAX_OCTETS];
  logic [6:0] press_len;
  logic [6:0] release_len;
  logic [6:0] octet_pos;
  logic oversize;
  logic press_alike;
  logic release_alike;

  rpl_pkg::rpl_result_t awaited_results [$];
  int mismatch_count = 0;
  int items_sent = 0;
  int pop_stall = 0;
  bit steady = 1'b0;

  report_pattern_learner #(
    .MAX_REPORT_OCTETS(MAX_OCTETS)
  ) dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .push(push_req),
    .full(req_full),
    .operation_i(operation),
    .report_octet_i(octet_in),
    .endpoint_id_i(endpoint_in),
    .final_octet_i(final_in),
    .empty(res_empty),
    .pop(pop_req),
    .outcome_o(outcome_out),
    .confirm_accepted_o(accepted_out),
    .learn_stage_o(stage_out)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  task automatic report_mismatch(input string msg);
    $display("[%0t] %s", $time, msg);
    mismatch_count++;
  endtask

  // Idle length for either side: mostly none, some short, a few long.
  function automatic int idle_len();
    int roll;
    roll = $urandom_range(0, 99);
    if (steady || roll < 60) return 0;
    if (roll < 94) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic void clear_partial_report();
    octet_pos = '0;
    oversize = 1'b0;
    press_alike = 1'b1;
    release_alike = 1'b1;
  endfunction

  function automatic void restart_model();
    model_stage = LS_FIRST_PRESS;
    model_learned_ep = '0;
    press_len = '0;
    release_len = '0;
  endfunction

  // Verdict on a complete report that stayed inside the pattern store.
  function automatic rpl_pkg::outcome_e judge_report(input logic [6:0] len);
    logic is_press;
    logic is_release;
    is_press = press_alike && (len == press_len);
    is_release = release_alike && (len == release_len);
    if (model_stage > LS_SECOND_RELEASE) return rpl_pkg::OUT_IGNORED;
    if (model_stage == LS_FIRST_PRESS) begin
      model_learned_ep = model_report_ep;
      press_len = len;
      model_stage = LS_FIRST_RELEASE;
      return rpl_pkg::OUT_PRESS;
    end
    if (model_report_ep != model_learned_ep) begin
      model_stage = LS_FAILED;
      return rpl_pkg::OUT_REJECTED;
    end
    if (model_stage == LS_FIRST_RELEASE) begin
      if (is_press) return rpl_pkg::OUT_REPEAT;
      release_len = len;
      model_stage = LS_SECOND_PRESS;
      return rpl_pkg::OUT_CYCLE;
    end
    if (model_stage == LS_SECOND_PRESS) begin
      if (is_release) return rpl_pkg::OUT_REPEAT;
      if (!is_press) begin
        model_stage = LS_FAILED;
        return rpl_pkg::OUT_REJECTED;
      end
      model_stage = LS_SECOND_RELEASE;
      return rpl_pkg::OUT_PRESS;
    end
    if (is_press) return rpl_pkg::OUT_REPEAT;
    if (!is_release) begin
      model_stage = LS_FAILED;
      return rpl_pkg::OUT_REJECTED;
    end
    model_stage = LS_AWAIT;
    return rpl_pkg::OUT_READY;
  endfunction

  // Advance the shadow state by one accepted request and queue its result, if any.
  function automatic void predict_learner_step(input rpl_pkg::op_e op,
                                               input logic [7:0] octet,
                                               input logic [15:0] ep, input logic fin);
    rpl_pkg::rpl_result_t res;
    res.outcome = rpl_pkg::OUT_IGNORED;
    res.confirm_acc = 1'b0;
    case (op)
      rpl_pkg::OP_CONFIRM: begin
        clear_partial_report();
        if (model_stage == LS_AWAIT) begin
          model_stage = LS_COMPLETE;
          res.confirm_acc = 1'b1;
        end
      end
      rpl_pkg::OP_CANCEL: begin
        clear_partial_report();
        model_stage = LS_FAILED;
      end
      rpl_pkg::OP_RESTART: begin
        clear_partial_report();
        restart_model();
      end
      default: begin
        if (octet_pos == 0) model_report_ep = ep;
        if (octet_pos >= MAX_OCTETS) begin
          oversize = 1'b1;
        end else begin
          if (!(octet_pos < press_len && press_pattern[octet_pos[5:0]] == octet))
            press_alike = 1'b0;
          if (!(octet_pos < release_len && release_pattern[octet_pos[5:0]] == octet))
            release_alike = 1'b0;
          if (model_stage == LS_FIRST_PRESS) press_pattern[octet_pos[5:0]] = octet;
          else if (model_stage == LS_FIRST_RELEASE) release_pattern[octet_pos[5:0]] = octet;
          octet_pos = octet_pos + 7'd1;
        end
        if (!fin) return;
        res.outcome = oversize ? rpl_pkg::OUT_IGNORED : judge_report(octet_pos);
        clear_partial_report();
      end
    endcase
    res.stage = model_stage;
    awaited_results.push_back(res);
  endfunction

  // Accepted requests feed the shadow state before results of the same edge are checked.
  always @(posedge clk_i) begin : result_monitor
    rpl_pkg::rpl_result_t want;
    if (rst_ni && push_req && !req_full)
      predict_learner_step(operation, octet_in, endpoint_in, final_in);
    if (rst_ni && pop_req && !res_empty) begin
      if (awaited_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result: outcome %0d stage %0d",
                                  outcome_out, stage_out));
      end else begin
        want = awaited_results.pop_front();
        if (outcome_out !== want.outcome)
          report_mismatch($sformatf("outcome %0d, expected %0d", outcome_out, want.outcome));
        if (accepted_out !== want.confirm_acc)
          report_mismatch($sformatf("confirm_accepted %0b, expected %0b",
                                    accepted_out, want.confirm_acc));
        if (stage_out !== want.stage)
          report_mismatch($sformatf("learn_stage %0d, expected %0d", stage_out, want.stage));
      end
    end
  end

  // The consumer stalls at random between pops.
  always @(negedge clk_i) begin
    if (pop_stall != 0) begin
      pop_req <= 1'b0;
      pop_stall <= pop_stall - 1;
    end else begin
      pop_req <= 1'b1;
      pop_stall <= idle_len();
    end
  end

  // Drive one request at a falling edge and hold it until accepted.
  task automatic send_request(input rpl_pkg::op_e op, input logic [7:0] octet,
                              input logic [15:0] ep, input logic fin);
    int gap;
    operation = op;
    octet_in = octet;
    endpoint_in = ep;
    final_in = fin;
    push_req = 1'b1;
    @(posedge clk_i);
    while (req_full) @(posedge clk_i);
    items_sent++;
    @(negedge clk_i);
    gap = idle_len();
    if (gap != 0) begin
      push_req = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
  endtask

  // Only the first octet carries the real endpoint; the rest carry noise.
  task automatic send_report(input logic [7:0] pat [$], input logic [15:0] ep);
    for (int i = 0; i < pat.size(); i++)
      send_request(rpl_pkg::OP_OCTET, pat[i], (i == 0) ? ep : 16'($urandom),
                   i == pat.size() - 1);
  endtask

  task automatic wait_drained();
    push_req = 1'b0;
    while (awaited_results.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  function automatic int pick_len();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 70) return $urandom_range(1, 4);
    if (roll < 95) return $urandom_range(5, 16);
    return $urandom_range(17, MAX_OCTETS);
  endfunction

  task automatic make_pattern(output logic [7:0] pat [$], input int len);
    pat = {};
    repeat (len) pat.push_back(8'($urandom));
  endtask

  // A report of a learning session, now and then damaged, cut short or oversize.
  task automatic send_session_report(input logic [7:0] pat [$], input logic [15:0] ep);
    logic [7:0] sent [$];
    logic [15:0] sent_ep;
    int roll;
    int k;
    int n;
    sent = pat;
    sent_ep = ep;
    roll = $urandom_range(0, 99);
    if (roll < 3) begin
      k = $urandom_range(0, 15);
      sent_ep[k] = ~sent_ep[k];
    end else if (roll < 6) begin
      k = $urandom_range(0, sent.size() - 1);
      sent[k] = sent[k] ^ 8'($urandom_range(1, 255));
    end else if (roll < 8) begin
      if (sent.size() > 1 && $urandom_range(0, 1) == 1) void'(sent.pop_back());
      else if (sent.size() < MAX_OCTETS) sent.push_back(8'($urandom));
    end else if (roll < 10) begin
      // A partial report dropped by an operation request.
      k = $urandom_range(1, sent.size());
      for (int i = 0; i < k; i++) send_request(rpl_pkg::OP_OCTET, sent[i], sent_ep, 1'b0);
      send_request(rpl_pkg::op_e'($urandom_range(1, 3)), 8'($urandom), 16'($urandom),
                   1'($urandom));
    end else if (roll == 10) begin
      n = $urandom_range(MAX_OCTETS + 1, MAX_OCTETS + 6);
      for (int i = 0; i < n; i++)
        send_request(rpl_pkg::OP_OCTET, 8'($urandom), sent_ep, i == n - 1);
    end
    send_report(sent, sent_ep);
  endtask

  // Directed: one clean learning cycle with every repeat and a confirm.
  task automatic test_learning_cycle();
    logic [7:0] press_pat [$];
    logic [7:0] release_pat [$];
    press_pat = '{8'h00};
    release_pat = '{8'hFF, 8'h80};
    send_report(press_pat, 16'hFFFF);
    send_report(press_pat, 16'hFFFF);
    send_request(rpl_pkg::OP_CONFIRM, 8'h00, 16'h0000, 1'b0);
    send_report(release_pat, 16'hFFFF);
    send_report(release_pat, 16'hFFFF);
    send_report(press_pat, 16'hFFFF);
    send_report(press_pat, 16'hFFFF);
    send_report(release_pat, 16'hFFFF);
    // A report while awaiting confirmation is ignored.
    send_report(press_pat, 16'hFFFF);
    send_request(rpl_pkg::OP_CONFIRM, 8'hFF, 16'hFFFF, 1'b1);
    send_request(rpl_pkg::OP_CONFIRM, 8'h00, 16'h0000, 1'b0);
    wait_drained();
  endtask

  // Directed: foreign endpoint, wrong patterns, and operations inside a report.
  task automatic test_failures();
    logic [7:0] press_pat [$];
    logic [7:0] release_pat [$];
    logic [7:0] other_pat [$];
    press_pat = '{8'h5A};
    release_pat = '{8'hA5, 8'h3C};
    other_pat = '{8'hA5};
    send_request(rpl_pkg::OP_RESTART, 8'h00, 16'h0000, 1'b0);
    send_report(press_pat, 16'h0000);
    send_report(release_pat, 16'h8001);
    send_report(press_pat, 16'h0000);
    send_request(rpl_pkg::OP_RESTART, 8'h00, 16'h0000, 1'b0);
    send_report(press_pat, 16'h0000);
    send_report(release_pat, 16'h0000);
    send_report(other_pat, 16'h0000);
    send_request(rpl_pkg::OP_RESTART, 8'h00, 16'h0000, 1'b0);
    send_report(press_pat, 16'h0000);
    send_report(release_pat, 16'h0000);
    send_report(press_pat, 16'h0000);
    send_report(other_pat, 16'h0000);
    send_request(rpl_pkg::OP_RESTART, 8'h00, 16'h0000, 1'b0);
    send_request(rpl_pkg::OP_OCTET, 8'h5A, 16'h1234, 1'b0);
    send_request(rpl_pkg::OP_CONFIRM, 8'h00, 16'h0000, 1'b0);
    send_report(other_pat, 16'h1234);
    send_request(rpl_pkg::OP_OCTET, 8'h5A, 16'h1234, 1'b0);
    send_request(rpl_pkg::OP_CANCEL, 8'h00, 16'h0000, 1'b0);
    wait_drained();
  endtask

  // Directed: a report that fills the store, then one that overruns it.
  task automatic test_report_lengths();
    logic [7:0] press_pat [$];
    logic [7:0] release_pat [$];
    logic [7:0] long_pat [$];
    make_pattern(press_pat, MAX_OCTETS);
    make_pattern(release_pat, MAX_OCTETS);
    release_pat[MAX_OCTETS - 1] = ~press_pat[MAX_OCTETS - 1];
    make_pattern(long_pat, MAX_OCTETS + 1);
    send_request(rpl_pkg::OP_RESTART, 8'h00, 16'h0000, 1'b0);
    send_report(press_pat, 16'h00FF);
    send_report(long_pat, 16'h00FF);
    send_report(release_pat, 16'h00FF);
    send_request(rpl_pkg::OP_RESTART, 8'h00, 16'h0000, 1'b0);
    wait_drained();
  endtask

  task automatic send_noise();
    rpl_pkg::op_e op;
    repeat ($urandom_range(1, 8)) begin
      op = ($urandom_range(0, 99) < 70) ? rpl_pkg::OP_OCTET
                                        : rpl_pkg::op_e'($urandom_range(1, 3));
      send_request(op, 8'($urandom), 16'($urandom), $urandom_range(0, 2) == 0);
    end
  endtask

  task automatic run_learning_session();
    logic [7:0] press_pat [$];
    logic [7:0] release_pat [$];
    logic [15:0] ep;
    ep = 16'($urandom);
    make_pattern(press_pat, pick_len());
    make_pattern(release_pat, pick_len());
    if (release_pat.size() == press_pat.size() && release_pat[0] == press_pat[0])
      release_pat[0] = ~press_pat[0];
    if ($urandom_range(0, 9) != 0)
      send_request(rpl_pkg::OP_RESTART, 8'($urandom), 16'($urandom), 1'($urandom));
    send_session_report(press_pat, ep);
    if ($urandom_range(0, 3) == 0) send_session_report(press_pat, ep);
    send_session_report(release_pat, ep);
    if ($urandom_range(0, 3) == 0) send_session_report(release_pat, ep);
    send_session_report(press_pat, ep);
    if ($urandom_range(0, 3) == 0) send_session_report(press_pat, ep);
    send_session_report(release_pat, ep);
    if ($urandom_range(0, 5) == 0) send_session_report(press_pat, ep);
    if ($urandom_range(0, 6) != 0)
      send_request(rpl_pkg::OP_CONFIRM, 8'($urandom), 16'($urandom), 1'($urandom));
    if ($urandom_range(0, 5) == 0)
      send_request(rpl_pkg::op_e'($urandom_range(1, 3)), 8'($urandom), 16'($urandom),
                   1'($urandom));
  endtask

  // Random: mostly whole learning sessions with random content, some noise.
  task automatic test_random_sessions();
    int start;
    start = items_sent;
    while (items_sent - start < RANDOM_ITEMS) begin
      steady = ($urandom_range(0, 9) == 0);
      if ($urandom_range(0, 4) == 0) send_noise();
      else run_learning_session();
      if ($urandom_range(0, 19) == 0) wait_drained();
    end
    steady = 1'b0;
  endtask

  initial begin
    restart_model();
    model_report_ep = '0;
    clear_partial_report();
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    test_learning_cycle();
    test_failures();
    test_report_lengths();
    test_random_sessions();
    wait_drained();
    repeat (10) @(posedge clk_i);
    if (awaited_results.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", awaited_results.size()));
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #20_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+rtl/core
rtl/core/rpl_pkg.sv
rtl/core/rpl_front.sv
rtl/core/rpl_back.sv
rtl/core/rpl_res_fifo.sv
rtl/core/report_pattern_learner.sv
sim/report_pattern_learner_test.sv
